FILE: hw/rtl/gsp_pkg.sv
// Shared types, constants and command tables for the gamepad serial poll master.
`timescale 1ns / 1ps
`default_nettype none

package gsp_pkg;

  localparam int unsigned HalfWidth = 8;
  localparam int unsigned GapWidth  = 20;
  localparam int unsigned CfgIdxWidth  = 1;
  localparam int unsigned CfgDataWidth = GapWidth;
  localparam int unsigned ReportBytes  = 6;

  localparam logic [CfgIdxWidth-1:0] CfgHalfPeriod = 1'd0;
  localparam logic [CfgIdxWidth-1:0] CfgFrameGap   = 1'd1;

  localparam logic [HalfWidth-1:0] HalfReset = 8'd50;
  localparam logic [GapWidth-1:0]  GapReset  = 20'd6000;

  localparam logic [7:0] CmdStart   = 8'h01;
  localparam logic [7:0] CmdPoll    = 8'h42;
  localparam logic [7:0] IdAnalog   = 8'h73;
  localparam logic [3:0] PollLength = 4'd9;
  localparam logic [3:0] IdByte     = 4'd1;
  localparam logic [3:0] FirstReportByte = 4'd3;
  localparam logic [1:0] LastInitFrame   = 2'd2;

  typedef enum logic [3:0] {
    PhIdle = 4'd0,
    PhLow  = 4'd1,
    PhHigh = 4'd2,
    PhAck  = 4'd3,
    PhGap  = 4'd4
  } phase_e;

  typedef enum logic [1:0] {
    KindNone = 2'd0,
    KindPoll = 2'd1,
    KindInit = 2'd2,
    KindRsvd = 2'd3
  } kind_e;

  localparam logic [7:0] InitFrames [3][9] = '{
    '{8'h01, 8'h43, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h01, 8'h44, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h01, 8'h43, 8'h00, 8'h00, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A}
  };
  localparam logic [3:0] InitLengths [3] = '{4'd5, 4'd9, 4'd9};

  typedef struct packed {
    logic [1:0] action;
    logic       data_in;
    logic       ack_in;
  } in_item_t;

  typedef struct packed {
    logic       attention_n;
    logic       clock_out;
    logic       command_out;
    logic       busy_res;
    logic       done_res;
    logic       responded;
    logic [7:0] buttons_low;
    logic [7:0] buttons_high;
    logic [7:0] right_x;
    logic [7:0] right_y;
    logic [7:0] left_x;
    logic [7:0] left_y;
  } out_item_t;

  // Number of bytes in the frame that is currently being sent.
  function automatic logic [3:0] frame_len(kind_e kind, logic [1:0] frame);
    logic [3:0] len;
    if (kind == KindPoll) begin
      len = PollLength;
    end else if (frame < 2'd3) begin
      len = InitLengths[frame];
    end else begin
      len = 4'd1;
    end
    return len;
  endfunction

  // Command byte for a given position of a poll or init frame.
  function automatic logic [7:0] tx_byte(kind_e kind, logic [1:0] frame, logic [3:0] idx);
    logic [7:0] value;
    value = 8'h00;
    if (kind == KindPoll) begin
      if (idx == 4'd0) begin
        value = CmdStart;
      end else if (idx == 4'd1) begin
        value = CmdPoll;
      end
    end else if (frame < 2'd3 && idx < 4'd9) begin
      value = InitFrames[frame][idx];
    end
    return value;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gsp_if.sv
// Valid/ready channel interfaces for the tick samples and the line/report results.
`timescale 1ns / 1ps
`default_nettype none

interface gsp_in_if;
  logic              valid;
  logic              ready;
  gsp_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface gsp_out_if;
  logic               valid;
  logic               ready;
  gsp_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gamepad_serial_poll_master.sv
// Gamepad serial poll master: sequencer, report capture and result register.
`timescale 1ns / 1ps
`default_nettype none

// The result for an input transaction appears in the output register in the cycle after the
//   transaction is accepted, computed in a single pass from the sequencer state.
// Throughput: one input transaction per cycle; the output register is refilled in the same
//   cycle that its contents are taken, so only a stalled output holds the input back.
// Reset (asynchronous, active low): sequencer idle, report bytes and responded cleared,
//   half period back to 50 ticks and frame gap back to 6000 ticks, output register empty.
module gamepad_serial_poll_master (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  gsp_in_if.sink                                  in_if,
  gsp_out_if.source                               out_if,
  input  wire logic                               cfg_we_i,
  input  wire logic [gsp_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  wire logic [gsp_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  // Configuration registers.
  logic [gsp_pkg::HalfWidth-1:0] half_q;
  logic [gsp_pkg::GapWidth-1:0]  gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= gsp_pkg::HalfReset;
      gap_q  <= gsp_pkg::GapReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gsp_pkg::CfgHalfPeriod: half_q <= cfg_data_i[gsp_pkg::HalfWidth-1:0];
        gsp_pkg::CfgFrameGap:   gap_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state. Everything advances only on an accepted transaction, since each
  // transaction stands for one tick of the serial link.
  gsp_pkg::phase_e phase_q, phase_d;
  gsp_pkg::kind_e  kind_q, kind_d;
  logic [1:0]      frame_q, frame_d;
  logic [3:0]      byte_q, byte_d;
  logic [2:0]      bit_q, bit_d;
  logic [gsp_pkg::GapWidth-1:0] tick_q, tick_d;
  logic [7:0]      tx_q, tx_d;
  logic [7:0]      rx_q, rx_d;
  logic [7:0]      report_q [gsp_pkg::ReportBytes];
  logic [7:0]      report_d [gsp_pkg::ReportBytes];
  logic            resp_q, resp_d;
  logic            done_d;

  logic            in_accept;
  logic            out_valid_q;
  gsp_pkg::out_item_t out_q, out_d;

  // A new transaction is taken whenever the result register is free or being emptied.
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_accept   = in_if.valid && in_if.ready;

  logic [gsp_pkg::GapWidth-1:0] tick_inc;
  logic                         half_done;
  logic                         gap_done;
  logic [4:0]                   next_byte_pos;
  logic                         last_byte;
  logic [3:0]                   byte_inc;

  assign tick_inc  = tick_q + 20'd1;
  assign half_done = tick_inc >= {{(gsp_pkg::GapWidth-gsp_pkg::HalfWidth){1'b0}}, half_q};
  assign gap_done  = tick_inc >= gap_q;
  assign next_byte_pos = {1'b0, byte_q} + 5'd1;
  assign last_byte = next_byte_pos >= {1'b0, gsp_pkg::frame_len(kind_q, frame_q)};
  assign byte_inc  = byte_q + 4'd1;

  // Next-state logic: one tick of the link per accepted transaction.
  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    frame_d = frame_q;
    byte_d  = byte_q;
    bit_d   = bit_q;
    tick_d  = tick_q;
    tx_d    = tx_q;
    rx_d    = rx_q;
    resp_d  = resp_q;
    done_d  = 1'b0;
    for (int i = 0; i < gsp_pkg::ReportBytes; i++) begin
      report_d[i] = report_q[i];
    end

    case (phase_q)
      gsp_pkg::PhIdle: begin
        if (in_if.payload.action == gsp_pkg::KindPoll ||
            in_if.payload.action == gsp_pkg::KindInit) begin
          kind_d  = gsp_pkg::kind_e'(in_if.payload.action);
          frame_d = 2'd0;
          byte_d  = 4'd0;
          tx_d    = gsp_pkg::tx_byte(gsp_pkg::kind_e'(in_if.payload.action), 2'd0, 4'd0);
          bit_d   = 3'd0;
          tick_d  = '0;
          phase_d = gsp_pkg::PhLow;
        end
      end
      gsp_pkg::PhLow: begin
        tick_d = tick_inc;
        if (half_done) begin
          // Data is sampled on the tick that closes the low phase.
          rx_d    = {in_if.payload.data_in, rx_q[7:1]};
          tick_d  = '0;
          phase_d = gsp_pkg::PhHigh;
        end
      end
      gsp_pkg::PhHigh: begin
        tick_d = tick_inc;
        if (half_done) begin
          tick_d = '0;
          if (bit_q != 3'd7) begin
            bit_d   = bit_q + 3'd1;
            tx_d    = {1'b0, tx_q[7:1]};
            phase_d = gsp_pkg::PhLow;
          end else begin
            // Byte complete: capture the id or a report byte during a poll.
            if (kind_q == gsp_pkg::KindPoll) begin
              if (byte_q == gsp_pkg::IdByte) begin
                resp_d = (rx_q == gsp_pkg::IdAnalog);
              end
              for (int i = 0; i < gsp_pkg::ReportBytes; i++) begin
                if (byte_q == gsp_pkg::FirstReportByte + 4'(i)) begin
                  report_d[i] = rx_q;
                end
              end
            end
            if (last_byte) begin
              if (kind_q == gsp_pkg::KindPoll) begin
                phase_d = gsp_pkg::PhIdle;
                done_d  = 1'b1;
              end else begin
                phase_d = gsp_pkg::PhGap;
              end
            end else begin
              phase_d = gsp_pkg::PhAck;
            end
          end
        end
      end
      gsp_pkg::PhAck: begin
        if (in_if.payload.ack_in) begin
          if (kind_q == gsp_pkg::KindPoll && byte_q == gsp_pkg::IdByte && !resp_q) begin
            // Wrong id: the poll stops after the id byte is acknowledged.
            phase_d = gsp_pkg::PhIdle;
            tick_d  = '0;
            done_d  = 1'b1;
          end else begin
            byte_d  = byte_inc;
            tx_d    = gsp_pkg::tx_byte(kind_q, frame_q, byte_inc);
            bit_d   = 3'd0;
            tick_d  = '0;
            phase_d = gsp_pkg::PhLow;
          end
        end
      end
      gsp_pkg::PhGap: begin
        tick_d = tick_inc;
        if (gap_done) begin
          tick_d = '0;
          if (frame_q < gsp_pkg::LastInitFrame) begin
            frame_d = frame_q + 2'd1;
            byte_d  = 4'd0;
            tx_d    = gsp_pkg::tx_byte(kind_q, frame_q + 2'd1, 4'd0);
            bit_d   = 3'd0;
            phase_d = gsp_pkg::PhLow;
          end else begin
            phase_d = gsp_pkg::PhIdle;
          end
        end
      end
      default: begin
        phase_d = gsp_pkg::PhIdle;
      end
    endcase
  end

  // Output logic: the line levels and status reflect the state after this tick.
  logic frame_active;

  always_comb begin
    frame_active = (phase_d == gsp_pkg::PhLow) || (phase_d == gsp_pkg::PhHigh) ||
                   (phase_d == gsp_pkg::PhAck);
    out_d.attention_n  = !frame_active;
    out_d.clock_out    = (phase_d != gsp_pkg::PhLow);
    out_d.command_out  = frame_active ? tx_d[0] : 1'b1;
    out_d.busy_res     = (phase_d != gsp_pkg::PhIdle);
    out_d.done_res     = done_d;
    out_d.responded    = resp_d;
    out_d.buttons_low  = report_d[0];
    out_d.buttons_high = report_d[1];
    out_d.right_x      = report_d[2];
    out_d.right_y      = report_d[3];
    out_d.left_x       = report_d[4];
    out_d.left_y       = report_d[5];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gsp_pkg::PhIdle;
      kind_q  <= gsp_pkg::KindNone;
      frame_q <= 2'd0;
      byte_q  <= 4'd0;
      bit_q   <= 3'd0;
      tick_q  <= '0;
      tx_q    <= 8'h00;
      rx_q    <= 8'h00;
      resp_q  <= 1'b0;
      for (int i = 0; i < gsp_pkg::ReportBytes; i++) begin
        report_q[i] <= 8'h00;
      end
    end else if (in_accept) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      frame_q <= frame_d;
      byte_q  <= byte_d;
      bit_q   <= bit_d;
      tick_q  <= tick_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      resp_q  <= resp_d;
      for (int i = 0; i < gsp_pkg::ReportBytes; i++) begin
        report_q[i] <= report_d[i];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= out_d;
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

  // A finished poll is never reported as still busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> !out_q.busy_res)
    else $error("done pulse while busy");

  // The serial clock only goes low inside an active frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.clock_out |-> !out_q.attention_n && out_q.busy_res)
    else $error("clock low outside a frame");

  // An idle sequencer without a start request stays idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && phase_q == gsp_pkg::PhIdle &&
    in_if.payload.action != gsp_pkg::KindPoll &&
    in_if.payload.action != gsp_pkg::KindInit |=> phase_q == gsp_pkg::PhIdle)
    else $error("sequencer left idle without a request");

  // The state only moves on an accepted transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(phase_q) && $stable(tick_q))
    else $error("sequencer advanced without a transaction");

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for the gamepad serial poll master, driven one tick at a time.
`timescale 1ns / 1ps

module tb;

  // Each input transaction is one sampled tick of the link. Each tick produces exactly one
  // line/report transaction, so a single in-order queue of expected lines is enough.
  localparam int          StallLimit = 1000;
  localparam int          TailCycles = 4;
  localparam int          HoldCycles = 48;
  localparam int          PrintCap   = 40;
  localparam logic [7:0]  ResetHalf  = 8'd50;
  localparam logic [19:0] ResetGap   = 20'd6000;
  localparam logic [7:0]  PollStart  = 8'h01;
  localparam logic [7:0]  PollCmd    = 8'h42;
  localparam logic [7:0]  AnalogId   = 8'h73;
  localparam logic [7:0]  ReportMark = 8'h5A;

  // Command bytes of the three configuration frames sent by the init sequence.
  localparam logic [7:0] SetupBytes [3][9] = '{
    '{8'h01, 8'h43, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h01, 8'h44, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h01, 8'h43, 8'h00, 8'h00, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A}
  };
  localparam int SetupLen [3] = '{5, 9, 9};

  typedef struct {
    gsp_pkg::in_item_t  tick;
    bit                 typed;
    gsp_pkg::out_item_t line;
  } step_row_t;

  typedef struct {
    logic [7:0]  half;
    logic [19:0] gap;
    int          seqs;
    int          tx_pct;
    int          rx_pct;
    bit          setups;
    bit          bad_only;
    int          pause_after;
    int          hold_after;
  } link_setting_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [gsp_pkg::CfgIdxWidth-1:0]  cfg_idx;
  logic [gsp_pkg::CfgDataWidth-1:0] cfg_data;

  gsp_in_if  tick_ch ();
  gsp_out_if line_ch ();

  gamepad_serial_poll_master dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (tick_ch),
    .out_if     (line_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // Predicted sequencer state, mirrored tick by tick from the accepted input transactions.
  gsp_pkg::phase_e seq_phase;
  gsp_pkg::kind_e  seq_kind;
  logic [1:0]  frame_no;
  logic [3:0]  byte_no;
  logic [2:0]  bit_no;
  logic [19:0] phase_ticks;
  logic [7:0]  cmd_shift;
  logic [7:0]  reply_shift;
  logic [7:0]  pad_report [6];
  logic        id_ok;
  logic        poll_done;
  logic [7:0]  half_ticks;
  logic [19:0] gap_ticks;

  // The emulated controller: the bytes it returns in the current frame and its acknowledge delay.
  logic [7:0] reply_script [9];
  int ack_hold;
  int ack_seen;
  int starts_left;
  bit allow_setups;
  bit bad_ids_only;

  gsp_pkg::out_item_t pending_lines [$];
  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  hold_req;
  int  quiet_cycles;
  int  mismatches;
  int  ticks_sent;
  int  lines_checked;
  int  good_polls;
  int  bad_polls;
  int  setups_done;

  task automatic log_mismatch(input string what);
    mismatches++;
    if (mismatches <= PrintCap) begin
      $display("[%0t] mismatch on line %0d: %s", $realtime, lines_checked, what);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // Loads the next command byte and starts its first low clock phase.
  task automatic start_byte();
    cmd_shift = 8'h00;
    if (seq_kind == gsp_pkg::KindPoll) begin
      if (byte_no == 4'd0) begin
        cmd_shift = PollStart;
      end else if (byte_no == 4'd1) begin
        cmd_shift = PollCmd;
      end
    end else if (frame_no < 2'd3 && byte_no < 4'd9) begin
      cmd_shift = SetupBytes[frame_no][byte_no];
    end
    bit_no = '0;
    phase_ticks = '0;
    seq_phase = gsp_pkg::PhLow;
  endtask

  task automatic end_poll();
    seq_phase = gsp_pkg::PhIdle;
    phase_ticks = '0;
    poll_done = 1'b1;
    if (id_ok) begin
      good_polls++;
    end else begin
      bad_polls++;
    end
  endtask

  // Advances the predicted link by one tick and returns the line state that follows it.
  task automatic advance_link(input gsp_pkg::in_item_t t, output gsp_pkg::out_item_t o);
    logic live;
    int   frame_len;
    poll_done = 1'b0;
    case (seq_phase)
      gsp_pkg::PhIdle: begin
        if (t.action == gsp_pkg::KindPoll || t.action == gsp_pkg::KindInit) begin
          seq_kind = gsp_pkg::kind_e'(t.action);
          frame_no = '0;
          byte_no = '0;
          start_byte();
        end
      end
      gsp_pkg::PhLow: begin
        phase_ticks = phase_ticks + 20'd1;
        if (phase_ticks >= {12'd0, half_ticks}) begin
          reply_shift = {t.data_in, reply_shift[7:1]};
          phase_ticks = '0;
          seq_phase = gsp_pkg::PhHigh;
        end
      end
      gsp_pkg::PhHigh: begin
        phase_ticks = phase_ticks + 20'd1;
        if (phase_ticks >= {12'd0, half_ticks}) begin
          phase_ticks = '0;
          if (bit_no < 3'd7) begin
            bit_no = bit_no + 3'd1;
            cmd_shift = cmd_shift >> 1;
            seq_phase = gsp_pkg::PhLow;
          end else begin
            // Byte finished: the id byte sets the responded flag, bytes three to eight fill the report.
            if (seq_kind == gsp_pkg::KindPoll) begin
              if (byte_no == 4'd1) begin
                id_ok = (reply_shift == AnalogId);
              end else if (byte_no >= 4'd3 && byte_no <= 4'd8) begin
                pad_report[byte_no - 4'd3] = reply_shift;
              end
            end
            if (seq_kind == gsp_pkg::KindPoll) begin
              frame_len = 9;
            end else if (frame_no < 2'd3) begin
              frame_len = SetupLen[frame_no];
            end else begin
              frame_len = 1;
            end
            if (int'(byte_no) + 1 >= frame_len) begin
              if (seq_kind == gsp_pkg::KindPoll) begin
                end_poll();
              end else begin
                seq_phase = gsp_pkg::PhGap;
              end
            end else begin
              seq_phase = gsp_pkg::PhAck;
            end
          end
        end
      end
      gsp_pkg::PhAck: begin
        if (t.ack_in) begin
          if (seq_kind == gsp_pkg::KindPoll && byte_no == 4'd1 && !id_ok) begin
            end_poll();
          end else begin
            byte_no = byte_no + 4'd1;
            start_byte();
          end
        end
      end
      gsp_pkg::PhGap: begin
        phase_ticks = phase_ticks + 20'd1;
        if (phase_ticks >= gap_ticks) begin
          phase_ticks = '0;
          if (frame_no < 2'd2) begin
            frame_no = frame_no + 2'd1;
            byte_no = '0;
            start_byte();
          end else begin
            seq_phase = gsp_pkg::PhIdle;
            setups_done++;
          end
        end
      end
      default: seq_phase = gsp_pkg::PhIdle;
    endcase

    live = (seq_phase == gsp_pkg::PhLow || seq_phase == gsp_pkg::PhHigh ||
            seq_phase == gsp_pkg::PhAck);
    o.attention_n  = !live;
    o.clock_out    = (seq_phase != gsp_pkg::PhLow);
    o.command_out  = live ? cmd_shift[0] : 1'b1;
    o.busy_res     = (seq_phase != gsp_pkg::PhIdle);
    o.done_res     = poll_done;
    o.responded    = id_ok;
    o.buttons_low  = pad_report[0];
    o.buttons_high = pad_report[1];
    o.right_x      = pad_report[2];
    o.right_y      = pad_report[3];
    o.left_x       = pad_report[4];
    o.left_y       = pad_report[5];
  endtask

  // Chooses the pins for the next tick as a well-behaved controller would drive them, with
  // random action codes while busy and an occasional corrupted data bit.
  task automatic pick_tick(output gsp_pkg::in_item_t t);
    int r;
    bit good;
    t.action  = 2'($urandom_range(0, 3));
    t.data_in = 1'($urandom_range(0, 1));
    t.ack_in  = 1'($urandom_range(0, 1));
    if (seq_phase != gsp_pkg::PhAck) begin
      ack_seen = 0;
      ack_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 2);
    end
    case (seq_phase)
      gsp_pkg::PhIdle: begin
        if (starts_left > 0 && $urandom_range(0, 1) == 0) begin
          starts_left--;
          r = $urandom_range(0, 9);
          foreach (reply_script[i]) begin
            case ($urandom_range(0, 5))
              0:       reply_script[i] = 8'h00;
              1:       reply_script[i] = 8'hFF;
              default: reply_script[i] = 8'($urandom);
            endcase
          end
          if (allow_setups && !bad_ids_only && r < 3) begin
            t.action = gsp_pkg::KindInit;
          end else begin
            t.action = gsp_pkg::KindPoll;
            good = !bad_ids_only && r >= 5;
            if (good) begin
              reply_script[1] = AnalogId;
            end else begin
              while (reply_script[1] == AnalogId) begin
                reply_script[1] = 8'($urandom);
              end
            end
            if ($urandom_range(0, 7) != 0) begin
              reply_script[2] = ReportMark;
            end
          end
        end else begin
          t.action = $urandom_range(0, 1) ? gsp_pkg::KindNone : gsp_pkg::KindRsvd;
        end
      end
      gsp_pkg::PhLow: begin
        if ($urandom_range(0, 63) != 0) begin
          t.data_in = reply_script[byte_no][bit_no];
        end
      end
      gsp_pkg::PhAck: begin
        t.ack_in = (ack_seen >= ack_hold);
        ack_seen++;
      end
      default: ;
    endcase
  endtask

  // Offers one tick, possibly after a random idle burst, and records its expected line once
  // the transaction is accepted.
  task automatic offer_tick(input gsp_pkg::in_item_t t, input bit typed,
                            input gsp_pkg::out_item_t typed_line);
    gsp_pkg::out_item_t want;
    if (tx_idle_pct > 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    tick_ch.valid   <= 1'b1;
    tick_ch.payload <= t;
    @(posedge clk_i);
    while (!tick_ch.ready) begin
      @(posedge clk_i);
    end
    advance_link(t, want);
    pending_lines.push_back(typed ? typed_line : want);
    ticks_sent++;
  endtask

  task automatic wait_for_lines();
    tick_ch.valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending_lines.size() != 0);
  endtask

  // Starts the given number of sequences and keeps ticking until the link is idle again.
  // A sequence that is already running is finished first.
  task automatic run_traffic(input int seqs, input int pause_after, input int hold_after);
    gsp_pkg::in_item_t t;
    gsp_pkg::out_item_t unused;
    int n;
    n = 0;
    unused = '0;
    starts_left = seqs;
    while (starts_left > 0 || seq_phase != gsp_pkg::PhIdle) begin
      if (n == pause_after) begin
        wait_for_lines();
      end
      if (n == hold_after) begin
        hold_req = 1'b1;
      end
      pick_tick(t);
      offer_tick(t, 1'b0, unused);
      n++;
    end
  endtask

  // Both registers go in on back-to-back edges; the write enable drops once after the pair.
  task automatic load_settings(input logic [7:0] half, input logic [19:0] gap);
    cfg_we   <= 1'b1;
    cfg_idx  <= gsp_pkg::CfgHalfPeriod;
    cfg_data <= {12'd0, half};
    @(posedge clk_i);
    cfg_idx  <= gsp_pkg::CfgFrameGap;
    cfg_data <= gap;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    half_ticks = half;
    gap_ticks = gap;
    @(posedge clk_i);
  endtask

  // Result side: checks every accepted line against the oldest expectation and drives ready
  // with random stall bursts plus one long hold-off when the stimulus asks for it.
  initial begin : line_sink
    gsp_pkg::out_item_t want;
    gsp_pkg::out_item_t got;
    int stall_left;
    int hold_left;
    line_ch.ready = 1'b0;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (line_ch.valid && line_ch.ready) begin
        got = line_ch.payload;
        if (pending_lines.size() == 0) begin
          log_mismatch("line arrived with nothing expected");
        end else begin
          want = pending_lines.pop_front();
          check_field("attention_n", 8'(got.attention_n), 8'(want.attention_n));
          check_field("clock_out", 8'(got.clock_out), 8'(want.clock_out));
          check_field("command_out", 8'(got.command_out), 8'(want.command_out));
          check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
          check_field("done_res", 8'(got.done_res), 8'(want.done_res));
          check_field("responded", 8'(got.responded), 8'(want.responded));
          check_field("buttons_low", got.buttons_low, want.buttons_low);
          check_field("buttons_high", got.buttons_high, want.buttons_high);
          check_field("right_x", got.right_x, want.right_x);
          check_field("right_y", got.right_y, want.right_y);
          check_field("left_x", got.left_x, want.left_x);
          check_field("left_y", got.left_y, want.left_y);
        end
        lines_checked++;
      end
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        line_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        line_ch.ready <= 1'b0;
      end else if (rx_idle_pct > 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
        stall_left = $urandom_range(1, 13) - 1;
        line_ch.ready <= 1'b0;
      end else begin
        line_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any cycle that moves a transaction on either side resets the count.
  always @(posedge clk_i) begin
    if ((tick_ch.valid && tick_ch.ready) || (line_ch.valid && line_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("[%0t] no transaction for %0d cycles, %0d lines still expected",
               $realtime, quiet_cycles, pending_lines.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    step_row_t          rows [10];
    link_setting_t      plan [5];
    gsp_pkg::out_item_t idle_line;
    gsp_pkg::out_item_t start_line;

    tick_ch.valid   = 1'b0;
    tick_ch.payload = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    rst_ni   = 1'b0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    mismatches = 0;
    ticks_sent = 0;
    lines_checked = 0;
    good_polls = 0;
    bad_polls = 0;
    setups_done = 0;
    tx_idle_pct = 15;
    rx_idle_pct = 15;
    ack_hold = 0;
    ack_seen = 0;
    starts_left = 0;
    allow_setups = 1'b1;
    bad_ids_only = 1'b0;

    // Predicted state after reset.
    seq_phase   = gsp_pkg::PhIdle;
    seq_kind    = gsp_pkg::KindNone;
    frame_no    = '0;
    byte_no     = '0;
    bit_no      = '0;
    phase_ticks = '0;
    cmd_shift   = '0;
    reply_shift = '0;
    foreach (pad_report[i]) pad_report[i] = 8'h00;
    id_ok       = 1'b0;
    poll_done   = 1'b0;
    half_ticks  = ResetHalf;
    gap_ticks   = ResetGap;
    // The poll started by the directed rows gets an all-zero reply, so it ends on a bad id.
    foreach (reply_script[i]) reply_script[i] = 8'h00;

    // Lines that can be read straight off the spec: released link, and the first low tick of
    // a poll sending 0x01 (least significant bit first, so the command line is high).
    idle_line = '0;
    idle_line.attention_n = 1'b1;
    idle_line.clock_out   = 1'b1;
    idle_line.command_out = 1'b1;
    start_line = '0;
    start_line.command_out = 1'b1;
    start_line.busy_res    = 1'b1;

    rows = '{
      '{'{gsp_pkg::KindNone, 1'b0, 1'b0}, 1'b1, idle_line},
      '{'{gsp_pkg::KindNone, 1'b1, 1'b1}, 1'b1, idle_line},
      // Action three must be treated like no action.
      '{'{gsp_pkg::KindRsvd, 1'b1, 1'b1}, 1'b1, idle_line},
      '{'{gsp_pkg::KindRsvd, 1'b0, 1'b0}, 1'b1, idle_line},
      '{'{gsp_pkg::KindPoll, 1'b1, 1'b0}, 1'b1, start_line},
      // A start request while busy is ignored; with the reset half period the bit is still low.
      '{'{gsp_pkg::KindInit, 1'b0, 1'b1}, 1'b1, start_line},
      '{'{gsp_pkg::KindPoll, 1'b1, 1'b1}, 1'b0, idle_line},
      '{'{gsp_pkg::KindRsvd, 1'b0, 1'b0}, 1'b0, idle_line},
      '{'{gsp_pkg::KindInit, 1'b1, 1'b0}, 1'b0, idle_line},
      '{'{gsp_pkg::KindNone, 1'b0, 1'b1}, 1'b0, idle_line}
    };

    // Link settings: fastest rate with no frame gap, a zero half period, the longest gap (polls
    // only), a slower rate with a bad-id poll, and a final stretch without any idling.
    plan = '{
      '{8'd1,   20'd0,      2, 12, 12, 1'b1, 1'b0, -1,  20},
      '{8'd0,   20'd3,      1, 30,  0, 1'b1, 1'b0, 20,  -1},
      '{8'd2,   20'hFFFFF,  1,  0, 30, 1'b0, 1'b0, -1,  -1},
      '{8'd4,   20'd5,      1, 10, 10, 1'b0, 1'b1, -1,  -1},
      '{8'd1,   20'd2,      1,  0,  0, 1'b1, 1'b0, -1,  -1}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run with the reset register values; the first link setting then finishes
    // the poll that they started.
    foreach (rows[i]) begin
      offer_tick(rows[i].tick, rows[i].typed, rows[i].line);
    end
    wait_for_lines();

    foreach (plan[p]) begin
      load_settings(plan[p].half, plan[p].gap);
      tx_idle_pct  = plan[p].tx_pct;
      rx_idle_pct  = plan[p].rx_pct;
      allow_setups = plan[p].setups;
      bad_ids_only = plan[p].bad_only;
      run_traffic(plan[p].seqs, plan[p].pause_after, plan[p].hold_after);
      wait_for_lines();
    end

    repeat (TailCycles) @(posedge clk_i);

    $display("Ran %0d tick transactions over six link settings: %0d good polls, %0d bad-id polls,",
             ticks_sent, good_polls, bad_polls);
    $display("%0d init sequences; %0d lines checked with %0d mismatches.",
             setups_done, lines_checked, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
